[rtl/hvl_pkg.sv]
`default_nettype none
package hvl_pkg;

  localparam int unsigned NAME_BYTES_STORED = 32;
  localparam int unsigned NAME_BITS = NAME_BYTES_STORED * 8;

  localparam logic [5:0] NAME_MAX_BYTES = 6'd32;
  localparam logic [5:0] COL_MAX = 6'd63;
  localparam logic [15:0] BUFFER_MAX_BYTES_DEFAULT = 16'd65535;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [2:0] REG_NAME_LENGTH = 3'd0;
  localparam logic [2:0] REG_NAME_LOW = 3'd1;
  localparam logic [2:0] REG_NAME_SECOND = 3'd2;
  localparam logic [2:0] REG_NAME_THIRD = 3'd3;
  localparam logic [2:0] REG_NAME_HIGH = 3'd4;

  typedef struct packed {
    logic [15:0] pos;
    logic [5:0]  col;
    logic        mismatch;
    logic        disq;
    logic        cr_pending;
    logic        skipping;
    logic        done;
  } hvl_state_t;

  typedef struct packed {
    logic        emit;
    logic        found;
    logic [15:0] offset;
  } hvl_result_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic hvl_state_t take_text(input hvl_state_t st, input logic [7:0] c,
                                           input logic [7:0] nb, input logic [5:0] len);
    hvl_state_t r;
    r = st;
    if (!(st.disq || st.skipping)) begin
      if (c == CH_COLON) begin
        if (!st.mismatch && len <= NAME_MAX_BYTES && st.col == len) begin
          r.skipping = 1'b1;
        end else begin
          r.disq = 1'b1;
        end
      end else begin
        if (st.col >= len || st.col >= NAME_MAX_BYTES || fold_case(c) != fold_case(nb)) begin
          r.mismatch = 1'b1;
        end
        if (st.col != COL_MAX) begin
          r.col = st.col + 6'd1;
        end
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/hvl_in_if.sv]
`default_nettype none
interface hvl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

[rtl/hvl_out_if.sv]
`default_nettype none
interface hvl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] value_offset;

  modport source (output valid, output found, output value_offset, input ready);
  modport sink (input valid, input found, input value_offset, output ready);
endinterface
`default_nettype wire

[rtl/hvl_regs.sv]
`default_nettype none
module hvl_regs
  import hvl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [5:0]           paddr,
  input  wire logic [63:0]          pwdata,
  output logic      [63:0]          prdata,
  output logic                      pready,
  output logic      [5:0]           name_length,
  output logic      [NAME_BITS-1:0] name_bytes
);

  logic [63:0] name_low;
  logic [63:0] name_second;
  logic [63:0] name_third;
  logic [63:0] name_high;
  logic        wr;
  logic [2:0]  index;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;
  assign index = paddr[5:3];
  assign name_bytes = {name_high, name_third, name_second, name_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      name_length <= '0;
      name_low <= '0;
      name_second <= '0;
      name_third <= '0;
      name_high <= '0;
    end else if (wr) begin
      case (index)
        REG_NAME_LENGTH: name_length <= pwdata[5:0];
        REG_NAME_LOW:    name_low <= pwdata;
        REG_NAME_SECOND: name_second <= pwdata;
        REG_NAME_THIRD:  name_third <= pwdata;
        REG_NAME_HIGH:   name_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_NAME_LENGTH: prdata = {58'd0, name_length};
      REG_NAME_LOW:    prdata = name_low;
      REG_NAME_SECOND: prdata = name_second;
      REG_NAME_THIRD:  prdata = name_third;
      REG_NAME_HIGH:   prdata = name_high;
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/hvl_step.sv]
`default_nettype none
module hvl_step
  import hvl_pkg::*;
#(
  parameter logic [15:0] BUFFER_MAX_BYTES = BUFFER_MAX_BYTES_DEFAULT
)
(
  input  wire hvl_state_t           st,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 last_byte,
  input  wire logic [5:0]           name_length,
  input  wire logic [NAME_BITS-1:0] name_bytes,
  output hvl_state_t                st_next,
  output hvl_result_t               res
);

  hvl_state_t t1;
  hvl_state_t n;
  logic [15:0] pos_inc;
  logic [7:0]  nb0;
  logic [7:0]  nb1;
  logic        blank;

  assign pos_inc = st.pos + 16'd1;
  assign blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB);
  assign nb0 = name_bytes[{st.col[4:0], 3'b000} +: 8];
  assign nb1 = name_bytes[{t1.col[4:0], 3'b000} +: 8];

  always_comb begin
    t1 = st;
    t1.pos = pos_inc;
    t1.cr_pending = 1'b0;
    if (st.cr_pending) begin
      t1 = take_text(t1, CH_CR, nb0, name_length);
    end
  end

  always_comb begin
    n = st;
    res = '0;
    if (st.done) begin
      n = st;
    end else if (st.pos >= BUFFER_MAX_BYTES) begin
      res.emit = 1'b1;
    end else begin
      n.pos = pos_inc;
      if (st.skipping) begin
        if (blank) begin
          if (last_byte) begin
            res.emit = 1'b1;
            res.found = 1'b1;
            res.offset = pos_inc;
          end
        end else begin
          res.emit = 1'b1;
          res.found = 1'b1;
          res.offset = st.pos;
        end
      end else if (data_byte == CH_NUL) begin
        res.emit = 1'b1;
      end else if (st.cr_pending && data_byte == CH_LF) begin
        n.cr_pending = 1'b0;
        n.col = '0;
        n.mismatch = 1'b0;
        n.disq = 1'b0;
        res.emit = last_byte;
      end else begin
        if (data_byte == CH_CR && !t1.skipping && !last_byte) begin
          n = t1;
          n.cr_pending = 1'b1;
        end else begin
          n = take_text(t1, data_byte, nb1, name_length);
        end
        if (last_byte) begin
          res.emit = 1'b1;
          res.found = n.skipping;
          res.offset = n.skipping ? pos_inc : 16'd0;
        end
      end
    end
    if (res.emit) begin
      n.done = 1'b1;
    end
    if (last_byte && (st.done || res.emit)) begin
      n = '0;
    end
    st_next = n;
  end

endmodule
`default_nettype wire

[rtl/http_header_value_locator_core.sv]
// Header value locator: takes a header block one byte per cycle on the header
// channel (unless a new result is due while the last one waits to be taken)
// and gives one result per search on the result channel: found and the byte
// offset where the value of the first line whose name matches the configured
// name (case-insensitive) starts. A search ends at a zero byte, at a byte
// marked last, at the value start, or at the buffer limit; bytes after the
// result give nothing until the byte marked last, which starts a new search.
// Each byte passes an input register and one pass of compare logic into the
// result register. Bytes that cause no result keep flowing while a result
// waits to be taken. Write the name registers only while no search is in
// progress.
`default_nettype none
module http_header_value_locator_core
  import hvl_pkg::*;
#(
  parameter logic [15:0] BUFFER_MAX_BYTES = BUFFER_MAX_BYTES_DEFAULT
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  hvl_in_if.sink           header,
  hvl_out_if.source        result
);

  logic [5:0]           name_length;
  logic [NAME_BITS-1:0] name_bytes;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        s1_go;
  logic        out_valid;
  logic        out_found;
  logic [15:0] out_offset;

  hvl_state_t  st;
  hvl_state_t  st_next;
  hvl_result_t res;

  hvl_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .name_length (name_length),
    .name_bytes  (name_bytes)
  );

  hvl_step #(
    .BUFFER_MAX_BYTES (BUFFER_MAX_BYTES)
  ) u_step (
    .st          (st),
    .data_byte   (s1_byte),
    .last_byte   (s1_last),
    .name_length (name_length),
    .name_bytes  (name_bytes),
    .st_next     (st_next),
    .res         (res)
  );

  assign s1_go = s1_valid && (!res.emit || !out_valid || result.ready);
  assign header.ready = !s1_valid || s1_go;

  assign result.valid = out_valid;
  assign result.found = out_found;
  assign result.value_offset = out_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (header.ready) begin
      s1_valid <= header.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (header.valid && header.ready) begin
      s1_byte <= header.data_byte;
      s1_last <= header.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_go) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && res.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.emit) begin
      out_found <= res.found;
      out_offset <= res.offset;
    end
  end

endmodule
`default_nettype wire
